// ===== sv/qvr_pkg.sv =====
// qvr_pkg: widths and shared types for the quaternion vector rotation pipeline
// no dependencies; imported by every qvr module and the core top level
package qvr_pkg;

  // field widths
  localparam int unsigned QuatWidth = 16;
  localparam int unsigned VecWidth  = 32;
  localparam int unsigned QuatFrac  = QuatWidth - 2;

  // quaternion products and matrix terms
  localparam int unsigned QProdW = 2 * QuatWidth;
  // diagonal terms and half off-diagonal terms need one bit more than a product
  localparam int unsigned EntW   = QProdW + 1;
  // matrix entry times vector component
  localparam int unsigned MProdW = EntW + VecWidth;
  // row sum: off-diagonal doubling plus three terms, with headroom
  localparam int unsigned SumW   = MProdW + 3;
  // binary point realignment after the two quaternion fractions
  localparam int unsigned Shift  = 2 * QuatFrac;
  localparam int unsigned ResW   = SumW - Shift;

  typedef logic signed [QuatWidth-1:0] quat_t;
  typedef logic signed [VecWidth-1:0]  vcomp_t;
  typedef logic signed [EntW-1:0]      ent_t;
  typedef logic signed [ResW-1:0]      res_comp_t;

  typedef struct packed {
    vcomp_t vx;
    vcomp_t vy;
    vcomp_t vz;
  } vec_t;

  // diagonals in full, off-diagonals held as half values (doubling done later)
  typedef struct packed {
    ent_t d0;
    ent_t d1;
    ent_t d2;
    ent_t xy_p;
    ent_t xy_m;
    ent_t xz_p;
    ent_t xz_m;
    ent_t yz_p;
    ent_t yz_m;
  } mat_t;

  typedef struct packed {
    res_comp_t rx;
    res_comp_t ry;
    res_comp_t rz;
  } res_t;

endpackage

// ===== sv/qvr_matrix.sv =====
// qvr_matrix: two pipeline stages, quaternion products then matrix terms
// depends on qvr_pkg
module qvr_matrix import qvr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  quat_t quat_w_i,
  input  quat_t quat_x_i,
  input  quat_t quat_y_i,
  input  quat_t quat_z_i,
  input  vec_t  vec_i,
  output logic  valid_o,
  output mat_t  mat_o,
  output vec_t  vec_o
);

  typedef logic signed [QProdW-1:0] qprod_t;

  qprod_t ww_q, xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, xw_q, yw_q, zw_q;
  vec_t   vec1_q, vec2_q;
  mat_t   mat_d, mat_q;
  logic   v1_q, v2_q;

  // stage one: ten 16x16 products
  always_ff @(posedge clk_i) begin
    ww_q   <= quat_w_i * quat_w_i;
    xx_q   <= quat_x_i * quat_x_i;
    yy_q   <= quat_y_i * quat_y_i;
    zz_q   <= quat_z_i * quat_z_i;
    xy_q   <= quat_x_i * quat_y_i;
    xz_q   <= quat_x_i * quat_z_i;
    yz_q   <= quat_y_i * quat_z_i;
    xw_q   <= quat_x_i * quat_w_i;
    yw_q   <= quat_y_i * quat_w_i;
    zw_q   <= quat_z_i * quat_w_i;
    vec1_q <= vec_i;
  end

  // stage two: sums, transposed arrangement
  always_comb begin
    mat_d.d0   = EntW'(ww_q) + EntW'(xx_q) - EntW'(yy_q) - EntW'(zz_q);
    mat_d.d1   = EntW'(ww_q) + EntW'(yy_q) - EntW'(xx_q) - EntW'(zz_q);
    mat_d.d2   = EntW'(ww_q) + EntW'(zz_q) - EntW'(xx_q) - EntW'(yy_q);
    mat_d.xy_p = EntW'(xy_q) + EntW'(zw_q);
    mat_d.xy_m = EntW'(xy_q) - EntW'(zw_q);
    mat_d.xz_p = EntW'(xz_q) + EntW'(yw_q);
    mat_d.xz_m = EntW'(xz_q) - EntW'(yw_q);
    mat_d.yz_p = EntW'(yz_q) + EntW'(xw_q);
    mat_d.yz_m = EntW'(yz_q) - EntW'(xw_q);
  end

  always_ff @(posedge clk_i) begin
    mat_q  <= mat_d;
    vec2_q <= vec1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;
  assign mat_o   = mat_q;
  assign vec_o   = vec2_q;

endmodule

// ===== sv/qvr_mac.sv =====
// qvr_mac: two pipeline stages, nine matrix-vector products then row sums
// depends on qvr_pkg
module qvr_mac import qvr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  mat_t mat_i,
  input  vec_t vec_i,
  output logic valid_o,
  output res_t res_o
);

  typedef logic signed [MProdW-1:0] mprod_t;
  typedef logic signed [SumW-1:0]   sum_t;

  mprod_t p00_q, p01_q, p02_q, p10_q, p11_q, p12_q, p20_q, p21_q, p22_q;
  sum_t   sx, sy, sz;
  res_t   res_d, res_q;
  logic   v3_q, v4_q;

  // stage three: one 33x32 product per matrix entry
  always_ff @(posedge clk_i) begin
    p00_q <= mat_i.d0   * vec_i.vx;
    p01_q <= mat_i.xy_p * vec_i.vy;
    p02_q <= mat_i.xz_m * vec_i.vz;
    p10_q <= mat_i.xy_m * vec_i.vx;
    p11_q <= mat_i.d1   * vec_i.vy;
    p12_q <= mat_i.yz_p * vec_i.vz;
    p20_q <= mat_i.xz_p * vec_i.vx;
    p21_q <= mat_i.yz_m * vec_i.vy;
    p22_q <= mat_i.d2   * vec_i.vz;
  end

  // stage four: row sums, off-diagonal terms doubled, then floor shift
  always_comb begin
    sx = SumW'(p00_q) + (SumW'(p01_q) <<< 1) + (SumW'(p02_q) <<< 1);
    sy = (SumW'(p10_q) <<< 1) + SumW'(p11_q) + (SumW'(p12_q) <<< 1);
    sz = (SumW'(p20_q) <<< 1) + (SumW'(p21_q) <<< 1) + SumW'(p22_q);
    res_d.rx = sx[SumW-1:Shift];
    res_d.ry = sy[SumW-1:Shift];
    res_d.rz = sz[SumW-1:Shift];
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v3_q <= valid_i;
      v4_q <= v3_q;
    end
  end

  assign valid_o = v4_q;
  assign res_o   = res_q;

endmodule

// ===== sv/qvr_sat.sv =====
// qvr_sat: output stage, clips each component to the vector width
// depends on qvr_pkg
module qvr_sat import qvr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  res_t   res_i,
  output logic   valid_o,
  output vcomp_t rot_x_o,
  output vcomp_t rot_y_o,
  output vcomp_t rot_z_o,
  output logic   saturated_o
);

  localparam vcomp_t VecMax = {1'b0, {(VecWidth-1){1'b1}}};
  localparam vcomp_t VecMin = {1'b1, {(VecWidth-1){1'b0}}};

  vcomp_t rx_d, ry_d, rz_d, rx_q, ry_q, rz_q;
  logic   ox, oy, oz;
  logic   valid_q, sat_q;

  // overflow when the bits above the output sign are not a sign extension
  always_comb begin
    ox   = (res_i.rx[ResW-1:VecWidth-1] != {(ResW-VecWidth+1){res_i.rx[ResW-1]}});
    oy   = (res_i.ry[ResW-1:VecWidth-1] != {(ResW-VecWidth+1){res_i.ry[ResW-1]}});
    oz   = (res_i.rz[ResW-1:VecWidth-1] != {(ResW-VecWidth+1){res_i.rz[ResW-1]}});
    rx_d = ox ? (res_i.rx[ResW-1] ? VecMin : VecMax) : res_i.rx[VecWidth-1:0];
    ry_d = oy ? (res_i.ry[ResW-1] ? VecMin : VecMax) : res_i.ry[VecWidth-1:0];
    rz_d = oz ? (res_i.rz[ResW-1] ? VecMin : VecMax) : res_i.rz[VecWidth-1:0];
  end

  always_ff @(posedge clk_i) begin
    rx_q <= rx_d;
    ry_q <= ry_d;
    rz_q <= rz_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sat_q   <= 1'b0;
    end else begin
      valid_q <= valid_i;
      sat_q   <= valid_i & (ox | oy | oz);
    end
  end

  assign valid_o     = valid_q;
  assign rot_x_o     = rx_q;
  assign rot_y_o     = ry_q;
  assign rot_z_o     = rz_q;
  assign saturated_o = sat_q;

endmodule

// ===== sv/quaternion_vector_rotate_core.sv =====
// quaternion_vector_rotate_core: top level of the quaternion vector rotation pipeline
// depends on qvr_pkg, qvr_matrix, qvr_mac and qvr_sat
//
// Rotates a Q16.16 vector by the matrix built from a Q2.14 quaternion (not
// normalised, so the vector is also scaled by |q|^2). A transaction is taken
// on every clock edge where start_i is high and busy_o low; busy_o is high
// only in reset and until the first clock edge after it, so one transaction
// can be issued per clock, back to back. Each result appears on
// rot_x_o/rot_y_o/rot_z_o and saturated_o for exactly one cycle, marked by
// valid_o, once its transaction has passed the five register stages below.
// Results come out in issue order and the receiver cannot stall them, so it
// must be ready to take one every cycle. The five register stages are:
// quaternion products, matrix terms, the nine 33x32 matrix-vector products,
// row sums with the floor shift, and saturation to 32 bits; throughput is
// one transaction per clock. saturated_o flags a clip on any of the three
// components.
module quaternion_vector_rotate_core import qvr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  output logic   busy_o,
  input  quat_t  quat_w_i,
  input  quat_t  quat_x_i,
  input  quat_t  quat_y_i,
  input  quat_t  quat_z_i,
  input  vcomp_t vec_x_i,
  input  vcomp_t vec_y_i,
  input  vcomp_t vec_z_i,
  output logic   valid_o,
  output vcomp_t rot_x_o,
  output vcomp_t rot_y_o,
  output vcomp_t rot_z_o,
  output logic   saturated_o
);

  logic busy_q;
  logic accept;
  vec_t vec_in;

  logic mat_valid;
  mat_t mat;
  vec_t mat_vec;

  logic res_valid;
  res_t res;

  // hold off transactions from reset until the first clock edge after its release
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign accept = start_i & ~busy_q;

  assign vec_in.vx = vec_x_i;
  assign vec_in.vy = vec_y_i;
  assign vec_in.vz = vec_z_i;

  // stages one and two: quaternion products and matrix terms
  qvr_matrix u_matrix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .quat_w_i (quat_w_i),
    .quat_x_i (quat_x_i),
    .quat_y_i (quat_y_i),
    .quat_z_i (quat_z_i),
    .vec_i    (vec_in),
    .valid_o  (mat_valid),
    .mat_o    (mat),
    .vec_o    (mat_vec)
  );

  // stages three and four: matrix times vector, shifted back to Q16.16
  qvr_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mat_valid),
    .mat_i   (mat),
    .vec_i   (mat_vec),
    .valid_o (res_valid),
    .res_o   (res)
  );

  // stage five: clip and present the result
  qvr_sat u_sat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (res_valid),
    .res_i       (res),
    .valid_o     (valid_o),
    .rot_x_o     (rot_x_o),
    .rot_y_o     (rot_y_o),
    .rot_z_o     (rot_z_o),
    .saturated_o (saturated_o)
  );

  // every taken transaction produces a result strobe on valid_o
  a_accept_to_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni) accept |-> ##5 valid_o
  ) else $error("taken transaction gave no result after five clocks");

  // no result without a matching taken transaction
  a_result_has_source: assert property (
    @(posedge clk_i) disable iff (!rst_ni) valid_o |-> $past(accept, 5)
  ) else $error("result strobe without a matching transaction");

  // the clip flag only accompanies a result
  a_sat_with_valid: assert property (
    @(posedge clk_i) disable iff (!rst_ni) saturated_o |-> valid_o
  ) else $error("saturated flag raised outside a result cycle");

  // no transaction is taken while busy
  a_no_accept_busy: assert property (
    @(posedge clk_i) disable iff (!rst_ni) busy_o |=> !mat_valid || !$past(busy_o, 2)
  ) else $error("pipeline advanced from a cycle held busy");

endmodule

// ===== dv/quaternion_vector_rotate_core_tb.sv =====
// quaternion_vector_rotate_core_tb: self-checking bench for the quaternion vector rotation core
// depends on qvr_pkg and quaternion_vector_rotate_core; a table of directed rows, then random
// transactions in three idling phases, every result checked against a hand-written value or a bit-exact predictor
module quaternion_vector_rotate_core_tb import qvr_pkg::*;;

  // wide enough to hold every product and row sum exactly
  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    vcomp_t rx;
    vcomp_t ry;
    vcomp_t rz;
    logic   sat;
  } rot_result_t;

  // one transaction; known rows carry a hand-written result instead of a predicted one
  typedef struct packed {
    quat_t       qw;
    quat_t       qx;
    quat_t       qy;
    quat_t       qz;
    vcomp_t      vx;
    vcomp_t      vy;
    vcomp_t      vz;
    logic        known;
    rot_result_t result;
  } stim_row_t;

  localparam quat_t  QOne      = 16'sh4000;
  localparam quat_t  QMinusOne = 16'shC000;
  localparam quat_t  QHalf     = 16'sh2000;
  localparam quat_t  QMax      = 16'sh7FFF;
  localparam quat_t  QMin      = 16'sh8000;
  localparam vcomp_t VMax      = 32'sh7FFFFFFF;
  localparam vcomp_t VMin      = 32'sh80000000;

  localparam wide_t RotMax = (wide_t'(1) <<< (VecWidth - 1)) - 1;
  localparam wide_t RotMin = -(wide_t'(1) <<< (VecWidth - 1));

  localparam int unsigned NumDirected = 15;
  localparam int unsigned ItemsPerPhase = 200;
  localparam int unsigned DrainCycles = 8;

  // w, x, y, z, vx, vy, vz, known, {rx, ry, rz, sat}
  localparam stim_row_t DirectedRows [NumDirected] = '{
    // zero quaternion collapses any vector
    '{'0, '0, '0, '0, 32'sd1, 32'sd2, 32'sd3, 1'b1, '{'0, '0, '0, 1'b0}},
    '{'0, '0, '0, '0, VMax, VMin, VMax, 1'b1, '{'0, '0, '0, 1'b0}},
    // identity, either sign of w, passes the vector extremes through
    '{QOne, '0, '0, '0, VMax, VMin, '0, 1'b1, '{VMax, VMin, '0, 1'b0}},
    '{QMinusOne, '0, '0, '0, VMin, VMax, 32'sh12345678, 1'b1,
      '{VMin, VMax, 32'sh12345678, 1'b0}},
    // w = -2.0 scales by four, both extremes clip
    '{QMin, '0, '0, '0, VMax, VMin, '0, 1'b1, '{VMax, VMin, '0, 1'b1}},
    // half turns about each axis
    '{'0, QOne, '0, '0, 32'sd1000, 32'sd2000, -32'sd3000, 1'b1,
      '{32'sd1000, -32'sd2000, 32'sd3000, 1'b0}},
    '{'0, '0, QOne, '0, 32'sd1000, 32'sd2000, -32'sd3000, 1'b1,
      '{-32'sd1000, 32'sd2000, 32'sd3000, 1'b0}},
    '{'0, '0, '0, QOne, 32'sd1000, 32'sd2000, -32'sd3000, 1'b1,
      '{-32'sd1000, -32'sd2000, -32'sd3000, 1'b0}},
    // negating the most negative component overflows by one
    '{'0, QOne, '0, '0, '0, VMin, '0, 1'b1, '{'0, VMax, '0, 1'b1}},
    // non-unit quaternion scales by a quarter, floor toward minus infinity
    '{QHalf, '0, '0, '0, 32'sd4, -32'sd3, 32'sd3, 1'b1, '{32'sd1, -32'sd1, '0, 1'b0}},
    '{QMax, QMax, QMax, QMax, VMax, VMax, VMax, 1'b0, '0},
    '{QMin, QMin, QMin, QMin, VMin, VMin, VMin, 1'b0, '0},
    '{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
      32'sh55555555, 32'shAAAAAAAA, 32'sh55555555, 1'b0, '0},
    // quarter turn about z
    '{16'sh2D41, '0, '0, 16'sh2D41, 32'sh00010000, '0, 32'sh00010000, 1'b0, '0},
    '{16'shFFFF, 16'sh0001, 16'shFFFF, 16'sh0001, -32'sd1, 32'sd1, -32'sd1, 1'b0, '0}
  };

  logic   clk_i;
  logic   rst_ni    = 1'b0;
  logic   start_i   = 1'b0;
  quat_t  quat_w_i  = '0;
  quat_t  quat_x_i  = '0;
  quat_t  quat_y_i  = '0;
  quat_t  quat_z_i  = '0;
  vcomp_t vec_x_i   = '0;
  vcomp_t vec_y_i   = '0;
  vcomp_t vec_z_i   = '0;
  logic   busy_o;
  logic   valid_o;
  vcomp_t rot_x_o;
  vcomp_t rot_y_o;
  vcomp_t rot_z_o;
  logic   saturated_o;

  rot_result_t pending_rotations [$];
  int unsigned issued_count  = 0;
  int unsigned checked_count = 0;
  int unsigned clipped_count = 0;
  int unsigned mismatch_count = 0;

  quaternion_vector_rotate_core u_top (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .quat_w_i,
    .quat_x_i,
    .quat_y_i,
    .quat_z_i,
    .vec_x_i,
    .vec_y_i,
    .vec_z_i,
    .valid_o,
    .rot_x_o,
    .rot_y_o,
    .rot_z_o,
    .saturated_o
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic vcomp_t clip_component(input wide_t v, inout logic flag);
    if (v > RotMax) begin
      flag = 1'b1;
      return VMax;
    end
    if (v < RotMin) begin
      flag = 1'b1;
      return VMin;
    end
    return vcomp_t'(v);
  endfunction

  // matrix from the raw quaternion, in the block's transposed arrangement, times the vector
  function automatic rot_result_t rotate_vector(input stim_row_t s);
    wide_t w, x, y, z, vx, vy, vz;
    wide_t ww, xx, yy, zz, xy, xz, yz, xw, yw, zw;
    wide_t d0, d1, d2, xyp, xym, xzp, xzm, yzp, yzm;
    rot_result_t r;
    w = s.qw; x = s.qx; y = s.qy; z = s.qz;
    vx = s.vx; vy = s.vy; vz = s.vz;
    ww = w * w; xx = x * x; yy = y * y; zz = z * z;
    xy = x * y; xz = x * z; yz = y * z;
    xw = x * w; yw = y * w; zw = z * w;
    d0 = ww + xx - yy - zz;
    d1 = ww + yy - xx - zz;
    d2 = ww + zz - xx - yy;
    xyp = (xy + zw) <<< 1;
    xym = (xy - zw) <<< 1;
    xzp = (xz + yw) <<< 1;
    xzm = (xz - yw) <<< 1;
    yzp = (yz + xw) <<< 1;
    yzm = (yz - xw) <<< 1;
    r.sat = 1'b0;
    r.rx = clip_component((d0 * vx + xyp * vy + xzm * vz) >>> Shift, r.sat);
    r.ry = clip_component((xym * vx + d1 * vy + yzp * vz) >>> Shift, r.sat);
    r.rz = clip_component((xzp * vx + yzm * vy + d2 * vz) >>> Shift, r.sat);
    return r;
  endfunction

  // mix of unit-range values, extremes and raw bit patterns
  function automatic quat_t rand_quat_comp();
    case ($urandom_range(0, 3))
      0: return quat_t'($signed($urandom_range(0, 32767)) - 16384);
      1: begin
        case ($urandom_range(0, 3))
          0: return QMin;
          1: return QMax;
          2: return QOne;
          default: return '0;
        endcase
      end
      default: return quat_t'($urandom);
    endcase
  endfunction

  function automatic vcomp_t rand_vec_comp();
    case ($urandom_range(0, 3))
      0: return vcomp_t'($signed($urandom_range(0, 2097151)) - 1048576);
      1: begin
        case ($urandom_range(0, 3))
          0: return VMin;
          1: return VMax;
          2: return -32'sd1;
          default: return '0;
        endcase
      end
      default: return vcomp_t'($urandom);
    endcase
  endfunction

  // drive one transaction, hold it until taken, then idle each cycle with the given odds
  task automatic issue_rotation(input stim_row_t row, input int unsigned idle_pct);
    quat_w_i <= row.qw;
    quat_x_i <= row.qx;
    quat_y_i <= row.qy;
    quat_z_i <= row.qz;
    vec_x_i  <= row.vx;
    vec_y_i  <= row.vy;
    vec_z_i  <= row.vz;
    start_i  <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_rotations.push_back(row.known ? row.result : rotate_vector(row));
    issued_count++;
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // results cannot be stalled, so every valid cycle is checked against the oldest prediction
  always @(posedge clk_i) begin
    rot_result_t want;
    if (rst_ni && valid_o) begin
      if (pending_rotations.size() == 0) begin
        $error("result with no transaction outstanding: %0d %0d %0d sat %0b",
               rot_x_o, rot_y_o, rot_z_o, saturated_o);
        mismatch_count++;
      end else begin
        want = pending_rotations.pop_front();
        checked_count++;
        if (want.sat) clipped_count++;
        if (rot_x_o !== want.rx) begin
          $error("rot_x: expected %0d, got %0d", want.rx, rot_x_o);
          mismatch_count++;
        end
        if (rot_y_o !== want.ry) begin
          $error("rot_y: expected %0d, got %0d", want.ry, rot_y_o);
          mismatch_count++;
        end
        if (rot_z_o !== want.rz) begin
          $error("rot_z: expected %0d, got %0d", want.rz, rot_z_o);
          mismatch_count++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, saturated_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int unsigned idle_pct [3];
    stim_row_t   row;
    idle_pct = '{23, 76, 0};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned i = 0; i < NumDirected; i++) begin
      issue_rotation(DirectedRows[i], idle_pct[0]);
    end

    // sender gaps: occasional, then frequent, then none at all
    for (int unsigned p = 0; p < 3; p++) begin
      for (int unsigned i = 0; i < ItemsPerPhase; i++) begin
        row = '0;
        row.qw = rand_quat_comp();
        row.qx = rand_quat_comp();
        row.qy = rand_quat_comp();
        row.qz = rand_quat_comp();
        row.vx = rand_vec_comp();
        row.vy = rand_vec_comp();
        row.vz = rand_vec_comp();
        issue_rotation(row, idle_pct[p]);
      end
    end
    start_i <= 1'b0;

    while (pending_rotations.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d rotations issued (%0d from the table, the rest random over three gap phases)",
             issued_count, NumDirected);
    $display("%0d results checked, %0d of them clipped", checked_count, clipped_count);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule
